// File: hdl/mcqs_pkg.sv
// ----------------------------------------------------------------------------
// mcqs_pkg
// shared types and constants of the motor command queue sequencer
// ----------------------------------------------------------------------------
package mcqs_pkg;

  typedef enum logic [1:0] {
    CMD_ENABLE  = 2'd0,
    CMD_DISABLE = 2'd1,
    CMD_HOME    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STOPPED = 2'd0,
    ST_ENABLED = 2'd1,
    ST_RUNNING = 2'd2,
    ST_OTHER   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DRV_STOP   = 2'd0,
    DRV_ENABLE = 2'd1,
    DRV_RUN    = 2'd2,
    DRV_HOME   = 2'd3
  } drive_t;

  localparam logic signed [31:0] HOME_RESET = 32'sd15849882;

  typedef struct packed {
    logic               cmd_ok;
    cmd_t               cmd;
    status_t            status;
    logic               homed;
    logic signed [31:0] feedback;
  } tick_t;

  typedef struct packed {
    drive_t             drive;
    logic signed [31:0] position;
    logic               done;
    logic               dropped;
    logic [3:0]         count;
  } result_t;

endpackage

// File: hdl/mcqs_ram.sv
// ----------------------------------------------------------------------------
// mcqs_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mcqs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/mcqs_fifo.sv
// ----------------------------------------------------------------------------
// mcqs_fifo
// two entry queue that parts a producer from a consumer
// ----------------------------------------------------------------------------
module mcqs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign cnt_nxt = cnt_r + 2'(do_wr) - 2'(do_rd);
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr_r <= ~wptr_r;
      end
      if (do_rd) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/mcqs_front.sv
// ----------------------------------------------------------------------------
// mcqs_front
// takes input items, marks known commands and queues them for the back part
// ----------------------------------------------------------------------------
module mcqs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_msg_valid,
  input  logic [1:0]         in_msg_cmd,
  input  logic [1:0]         in_motor_status,
  input  logic               in_motor_homed,
  input  logic signed [31:0] in_feedback_position,
  input  logic               tick_pop,
  output logic               tick_empty,
  output mcqs_pkg::tick_t    tick
);

  import mcqs_pkg::*;

  tick_t tick_in;

  always_comb begin
    tick_in.cmd_ok   = in_msg_valid && (in_msg_cmd <= CMD_HOME);
    tick_in.cmd      = cmd_t'(in_msg_cmd);
    tick_in.status   = status_t'(in_motor_status);
    tick_in.homed    = in_motor_homed;
    tick_in.feedback = in_feedback_position;
  end

  mcqs_fifo #(
    .WIDTH($bits(tick_t))
  ) u_tick_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_push),
    .wr_data (tick_in),
    .full    (in_full),
    .rd_en   (tick_pop),
    .rd_data (tick),
    .empty   (tick_empty)
  );

endmodule

// File: hdl/mcqs_back.sv
// ----------------------------------------------------------------------------
// mcqs_back
// command ring and head execution against motor status, one tick a cycle on fire
// ----------------------------------------------------------------------------
module mcqs_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  mcqs_pkg::tick_t    tick,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_data,
  output mcqs_pkg::result_t  result
);

  import mcqs_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);

  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   pend_r, pend_nxt;
  logic signed [31:0] latch_r, latch_nxt;
  drive_t             last_drv_r, last_drv_nxt;
  logic signed [31:0] last_pos_r, last_pos_nxt;
  logic signed [31:0] home_r;
  logic               byp_r, byp_nxt;
  cmd_t               byp_cmd_r;

  logic               push;
  logic               drop;
  logic [IDX_W:0]     slot_sum;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   cnt_push;
  logic [IDX_W-1:0]   cnt_after;
  logic [IDX_W-1:0]   head_inc;
  logic [1:0]         ram_q;
  cmd_t               q_cmd;
  cmd_t               head_cmd;
  logic               finished;
  drive_t             drive;
  logic signed [31:0] pos;
  logic [IDX_W+3:0]   cnt_ext;

  // ring slot after the last waiting command
  always_comb begin
    push     = tick.cmd_ok && (pend_r < LAST_IDX);
    drop     = tick.cmd_ok && !push;
    slot_sum = {1'b0, head_r} + {1'b0, pend_r};
    wr_addr  = (slot_sum >= DEPTH_EXT) ? IDX_W'(slot_sum - DEPTH_EXT)
                                       : slot_sum[IDX_W-1:0];
    wr_en    = fire && push;
    cnt_push = pend_r + IDX_W'(push);
    head_inc = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
    q_cmd    = byp_r ? byp_cmd_r : cmd_t'(ram_q);
    head_cmd = (pend_r == '0) ? tick.cmd : q_cmd;
  end

  // head command against the motor status
  always_comb begin
    drive     = last_drv_r;
    pos       = last_pos_r;
    latch_nxt = latch_r;
    finished  = 1'b0;
    if (cnt_push != '0) begin
      case (head_cmd)
        CMD_ENABLE: begin
          if (tick.status == ST_RUNNING) begin
            drive    = DRV_RUN;
            pos      = latch_r;
            finished = 1'b1;
          end else if (tick.status == ST_ENABLED) begin
            drive     = DRV_RUN;
            pos       = tick.feedback;
            latch_nxt = tick.feedback;
          end else begin
            drive = DRV_ENABLE;
          end
        end
        CMD_DISABLE: begin
          if (tick.status != ST_STOPPED) begin
            drive = DRV_STOP;
          end else begin
            finished = 1'b1;
          end
        end
        default: begin
          drive    = tick.homed ? DRV_RUN : DRV_HOME;
          pos      = home_r;
          finished = tick.homed;
        end
      endcase
    end
  end

  always_comb begin
    cnt_after    = cnt_push - IDX_W'(finished);
    head_nxt     = head_r;
    pend_nxt     = pend_r;
    last_drv_nxt = last_drv_r;
    last_pos_nxt = last_pos_r;
    if (fire) begin
      head_nxt     = finished ? head_inc : head_r;
      pend_nxt     = cnt_after;
      last_drv_nxt = drive;
      last_pos_nxt = pos;
    end
    // entry written at the next head address is not yet visible at the read port
    byp_nxt = wr_en && (wr_addr == head_nxt);
  end

  always_comb begin
    cnt_ext         = {4'b0, cnt_after};
    result.drive    = drive;
    result.position = pos;
    result.done     = finished;
    result.dropped  = drop;
    result.count    = cnt_ext[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      pend_r     <= '0;
      latch_r    <= '0;
      last_drv_r <= DRV_STOP;
      last_pos_r <= '0;
      home_r     <= HOME_RESET;
      byp_r      <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      pend_r     <= pend_nxt;
      if (fire) begin
        latch_r <= latch_nxt;
      end
      last_drv_r <= last_drv_nxt;
      last_pos_r <= last_pos_nxt;
      if (cfg_we) begin
        home_r <= cfg_data;
      end
      byp_r      <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byp_cmd_r <= tick.cmd;
  end

  mcqs_ram #(
    .WIDTH(2),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (tick.cmd),
    .raddr (head_nxt),
    .rdata (ram_q)
  );

endmodule

// File: hdl/motor_command_queue_sequencer.sv
// ----------------------------------------------------------------------------
// motor_command_queue_sequencer
// queues enable, disable and home commands for one motor and runs the head
// command against the motor status, one result item per input item
// ----------------------------------------------------------------------------
// path: an accepted item waits in the front queue and its result in the result queue
// throughput: one item per cycle unless the result queue is full; each tick is
// done from the head entry read the cycle before, bypassing a fresh write
// reset: synchronous, active low; both item queues empty, ring empty, drive
// stop at position zero, home_position back to 15849882; ring entries are not
// cleared and are only read after they are written
module motor_command_queue_sequencer #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_msg_valid,
  input  logic [1:0]         in_msg_cmd,
  input  logic [1:0]         in_motor_status,
  input  logic               in_motor_homed,
  input  logic signed [31:0] in_feedback_position,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_drive_command,
  output logic signed [31:0] out_command_position,
  output logic               out_cmd_done,
  output logic               out_msg_dropped,
  output logic [3:0]         out_queue_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_home_position
);

  import mcqs_pkg::*;

  localparam logic [3:0] FULL_CNT = 4'((QUEUE_DEPTH - 1) % 16);

  tick_t   tick;
  logic    tick_empty;
  logic    res_full;
  logic    fire;
  result_t res_in;
  result_t res_out;

  assign cfg_ready = 1'b1;
  assign fire      = !tick_empty && !res_full;

  mcqs_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_msg_valid         (in_msg_valid),
    .in_msg_cmd           (in_msg_cmd),
    .in_motor_status      (in_motor_status),
    .in_motor_homed       (in_motor_homed),
    .in_feedback_position (in_feedback_position),
    .tick_pop             (fire),
    .tick_empty           (tick_empty),
    .tick                 (tick)
  );

  mcqs_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .tick     (tick),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_home_position),
    .result   (res_in)
  );

  mcqs_fifo #(
    .WIDTH($bits(result_t))
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fire),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  assign out_drive_command    = res_out.drive;
  assign out_command_position = res_out.position;
  assign out_cmd_done         = res_out.done;
  assign out_msg_dropped      = res_out.dropped;
  assign out_queue_count      = res_out.count;

  // an accepted item is waiting for the back part in the next cycle
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> !tick_empty)
    else $error("accepted item missing from front queue");

  // a result only shows up after the back part ran a tick
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(fire))
    else $error("result item without a tick");

  // a refused command means the ring was full
  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_in.dropped && !res_in.done) |-> (res_in.count == FULL_CNT))
    else $error("command dropped with room in the ring");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench of motor_command_queue_sequencer: control ticks go in through the
// input queue, each result item is predicted from a private copy of the
// command ring and compared field by field with what the block pops out
// ----------------------------------------------------------------------------
module tb;
  import mcqs_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;

  typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PATTERN} pop_mode_t;

  logic               clk                  = 1'b0;
  logic               rst_n                = 1'b0;
  logic               in_push              = 1'b0;
  logic               in_full;
  logic               in_msg_valid         = 1'b0;
  logic [1:0]         in_msg_cmd           = '0;
  logic [1:0]         in_motor_status      = '0;
  logic               in_motor_homed       = 1'b0;
  logic signed [31:0] in_feedback_position = '0;
  logic               out_empty;
  logic               out_pop              = 1'b0;
  logic [1:0]         out_drive_command;
  logic signed [31:0] out_command_position;
  logic               out_cmd_done;
  logic               out_msg_dropped;
  logic [3:0]         out_queue_count;
  logic               cfg_valid            = 1'b0;
  logic               cfg_ready;
  logic signed [31:0] cfg_home_position    = '0;

  motor_command_queue_sequencer #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_msg_valid        (in_msg_valid),
    .in_msg_cmd          (in_msg_cmd),
    .in_motor_status     (in_motor_status),
    .in_motor_homed      (in_motor_homed),
    .in_feedback_position(in_feedback_position),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_drive_command   (out_drive_command),
    .out_command_position(out_command_position),
    .out_cmd_done        (out_cmd_done),
    .out_msg_dropped     (out_msg_dropped),
    .out_queue_count     (out_queue_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_home_position   (cfg_home_position)
  );

  always #10 clk = ~clk;

  // private copy of the sequencer state
  cmd_t               ring [DEPTH];
  int                 ring_head  = 0;
  int                 ring_fill  = 0;
  logic signed [31:0] latch_pos  = '0;
  logic signed [31:0] prev_pos   = '0;
  logic signed [31:0] home_reg   = HOME_RESET;
  drive_t             prev_drive = DRV_STOP;

  result_t   expected_drive[$];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        bursty     = 1'b0;
  pop_mode_t pop_mode   = POP_ALWAYS;
  int        pop_ticks  = 0;

  task automatic predict_tick(input logic valid, input logic [1:0] cmd, input status_t status,
                              input logic homed, input logic signed [31:0] feedback);
    result_t            r;
    drive_t             drv;
    logic signed [31:0] pos;
    logic               finished;
    r        = '0;
    drv      = prev_drive;
    pos      = prev_pos;
    finished = 1'b0;
    if (valid && cmd <= CMD_HOME) begin
      if (ring_fill < DEPTH - 1) begin
        ring[(ring_head + ring_fill) % DEPTH] = cmd_t'(cmd);
        ring_fill++;
      end else begin
        r.dropped = 1'b1;
      end
    end
    if (ring_fill > 0) begin
      case (ring[ring_head])
        CMD_ENABLE: begin
          if (status == ST_RUNNING) begin
            drv      = DRV_RUN;
            pos      = latch_pos;
            finished = 1'b1;
          end else if (status == ST_ENABLED) begin
            drv       = DRV_RUN;
            pos       = feedback;
            latch_pos = feedback;
          end else begin
            drv = DRV_ENABLE;
          end
        end
        CMD_DISABLE: begin
          if (status != ST_STOPPED) drv = DRV_STOP;
          else finished = 1'b1;
        end
        default: begin
          drv      = homed ? DRV_RUN : DRV_HOME;
          pos      = home_reg;
          finished = homed;
        end
      endcase
      if (finished) begin
        ring_head = (ring_head + 1) % DEPTH;
        ring_fill--;
        r.done = 1'b1;
      end
    end
    prev_drive = drv;
    prev_pos   = pos;
    r.drive    = drv;
    r.position = pos;
    r.count    = ring_fill[3:0];
    expected_drive.push_back(r);
  endtask

  task automatic send_tick(input logic valid, input logic [1:0] cmd, input status_t status,
                           input logic homed, input logic signed [31:0] feedback);
    int gap;
    @(negedge clk);
    if (bursty && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_push              <= 1'b1;
    in_msg_valid         <= valid;
    in_msg_cmd           <= cmd;
    in_motor_status      <= status;
    in_motor_homed       <= homed;
    in_feedback_position <= feedback;
    do @(posedge clk); while (in_full);
    predict_tick(valid, cmd, status, homed, feedback);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic settle();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_home(input logic signed [31:0] value);
    settle();
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_home_position <= value;
    do @(posedge clk); while (!cfg_ready);
    home_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // motor follows the last drive unless the tick is noise
  task automatic random_ticks(input int n, input int valid_pct, input int noise_pct);
    logic               valid;
    logic [1:0]         cmd;
    status_t            status;
    logic               homed;
    logic signed [31:0] fb;
    for (int i = 0; i < n; i++) begin
      valid = $urandom_range(0, 99) < valid_pct;
      cmd   = ($urandom_range(0, 19) == 0) ? CMD_UNDEFINED
                                           : 2'($urandom_range(CMD_ENABLE, CMD_HOME));
      if ($urandom_range(0, 99) < noise_pct) begin
        status = status_t'($urandom_range(ST_STOPPED, ST_OTHER));
        homed  = 1'($urandom_range(0, 1));
      end else begin
        case (prev_drive)
          DRV_ENABLE: status = ST_ENABLED;
          DRV_RUN:    status = ST_RUNNING;
          DRV_STOP:   status = ST_STOPPED;
          default:    status = status_t'($urandom_range(ST_STOPPED, ST_OTHER));
        endcase
        homed = (prev_drive == DRV_HOME) && ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 15) == 0) fb = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      else fb = $urandom;
      send_tick(valid, cmd, status, homed, fb);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, want, got);
      end
    end
  endtask

  always @(negedge clk) begin
    if (pop_ticks == 0) begin
      pop_mode  = pop_mode_t'($urandom_range(POP_ALWAYS, POP_PATTERN));
      pop_ticks = $urandom_range(20, 80);
    end
    pop_ticks--;
    case (pop_mode)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_MOSTLY: out_pop <= $urandom_range(0, 3) != 0;
      POP_RARELY: out_pop <= $urandom_range(0, 3) == 0;
      default:    out_pop <= pop_ticks[2:0] < 3'd5;
    endcase
  end

  always @(posedge clk) begin : check_result
    result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t result item with none expected: drive %0d position %0h",
                   $time, out_drive_command, out_command_position);
        end
      end else begin
        want = expected_drive.pop_front();
        check_field("drive_command", 32'(want.drive), 32'(out_drive_command));
        check_field("command_position", want.position, out_command_position);
        check_field("cmd_done", 32'(want.done), 32'(out_cmd_done));
        check_field("msg_dropped", 32'(want.dropped), 32'(out_msg_dropped));
        check_field("queue_count", 32'(want.count), 32'(out_queue_count));
      end
    end
  end

  task automatic test_idle_ticks();
    send_tick(1'b0, CMD_HOME, ST_RUNNING, 1'b1, 32'sh7fffffff);
    send_tick(1'b1, CMD_UNDEFINED, ST_ENABLED, 1'b0, 32'sh80000000);
  endtask

  task automatic test_enable_command();
    send_tick(1'b1, CMD_ENABLE, ST_STOPPED, 1'b0, 32'sd5);
    send_tick(1'b0, CMD_ENABLE, ST_OTHER, 1'b1, 32'sd7);
    send_tick(1'b0, CMD_ENABLE, ST_ENABLED, 1'b0, 32'sh7fffffff);
    send_tick(1'b0, CMD_ENABLE, ST_ENABLED, 1'b0, 32'sh80000000);
    send_tick(1'b0, CMD_ENABLE, ST_RUNNING, 1'b0, 32'sd123);
  endtask

  task automatic test_disable_command();
    send_tick(1'b1, CMD_DISABLE, ST_RUNNING, 1'b0, -32'sd1);
    send_tick(1'b0, CMD_DISABLE, ST_STOPPED, 1'b0, 32'sd0);
  endtask

  task automatic test_home_command();
    send_tick(1'b1, CMD_HOME, ST_STOPPED, 1'b0, 32'sd99);
    write_home(32'sh80000000);
    send_tick(1'b0, CMD_HOME, ST_OTHER, 1'b1, 32'sd42);
  endtask

  task automatic test_queue_full();
    for (int i = 0; i < DEPTH; i++) begin
      send_tick(1'b1, CMD_ENABLE, ST_STOPPED, 1'b0, $urandom);
    end
  endtask

  task automatic test_tracking_motor();
    write_home(32'sh7fffffff);
    bursty = 1'b1;
    random_ticks(150, 25, 10);
  endtask

  task automatic test_queue_pressure();
    write_home(32'sd0);
    random_ticks(100, 90, 10);
  endtask

  task automatic test_noisy_status();
    write_home(-32'sd1);
    bursty = 1'b0;
    random_ticks(100, 50, 100);
  endtask

  task automatic test_random_home();
    write_home($urandom);
    bursty = 1'b1;
    random_ticks(150, 15, 20);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_enable_command();
    test_disable_command();
    test_home_command();
    test_queue_full();
    test_tracking_motor();
    test_queue_pressure();
    test_noisy_status();
    test_random_home();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("** motor_command_queue_sequencer: PASSED **");
    end else begin
      $display("** motor_command_queue_sequencer: FAILED **");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout");
    $display("** motor_command_queue_sequencer: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
hdl/mcqs_pkg.sv
hdl/mcqs_ram.sv
hdl/mcqs_fifo.sv
hdl/mcqs_front.sv
hdl/mcqs_back.sv
hdl/motor_command_queue_sequencer.sv
sim/tb.sv
